// ===== rtl/lba_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked block allocator package
// Shared operation codes, status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lba_pkg;

   localparam int MAX_LEN = 16;
   localparam int LEN_W   = 5;
   localparam int FREE_W  = 5;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_READ   = 3'd1,
      OP_UPDATE = 3'd2,
      OP_DELETE = 3'd3,
      OP_DATA   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_NO_SPACE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIND_RD,
      S_FIND_CMP,
      S_HEAD_RD,
      S_HEAD_LD,
      S_FREE_CHK,
      S_FREE_NX,
      S_START,
      S_RESULT,
      S_RD_CHK,
      S_RD_DATA,
      S_WSCAN,
      S_WLINK,
      S_TSCAN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       end_write;
      logic       find_clear;
      logic       find_next;
      logic       set_code;
      status_type code;
      logic       head_load;
      logic       free_step;
      logic       free_done;
      logic       ptr_follow;
      logic       start_write;
      logic       emit_status;
      logic       emit_char;
      logic       wscan_init;
      logic       wscan_next;
      logic       take;
      logic       link;
      logic       tclaim;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   write_idle;
      logic   id_match;
      logic   idx_last;
      logic   ptr_ok;
      logic   link_ok;
      logic   scan_used;
      logic   ptr_last;
      logic   slot_free;
      logic   prev_ok;
      logic   out_ready;
   } sts_type;

endpackage

// ===== rtl/lba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Linked block allocator controller
// Sequences table searches, chain walks, block scans and result delivery.
// ----------------------------------------------------------------------------
module lba_ctrl
   import lba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (sts.op)
               OP_DATA: state_in = sts.write_idle ? S_IDLE : S_WSCAN;
               OP_CREATE, OP_READ, OP_UPDATE, OP_DELETE: state_in = S_FIND_RD;
               default: state_in = S_IDLE;
            endcase
         end
         S_FIND_RD: state_in = S_FIND_CMP;
         S_FIND_CMP: begin
            if (sts.id_match) begin
               state_in = (sts.op == OP_CREATE) ? S_RESULT : S_HEAD_RD;
            end else if (sts.idx_last) begin
               state_in = (sts.op == OP_CREATE) ? S_START : S_RESULT;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_HEAD_RD: state_in = S_HEAD_LD;
         S_HEAD_LD: state_in = (sts.op == OP_READ) ? S_RD_CHK : S_FREE_CHK;
         S_FREE_CHK: begin
            if (sts.ptr_ok) begin
               state_in = S_FREE_NX;
            end else begin
               state_in = (sts.op == OP_UPDATE) ? S_START : S_RESULT;
            end
         end
         S_FREE_NX: state_in = S_FREE_CHK;
         S_START: state_in = S_RESULT;
         S_RESULT: begin
            if (sts.out_ready) state_in = S_IDLE;
         end
         S_RD_CHK: state_in = sts.ptr_ok ? S_RD_DATA : S_RESULT;
         S_RD_DATA: begin
            if (sts.out_ready) state_in = sts.link_ok ? S_RD_CHK : S_IDLE;
         end
         S_WSCAN: begin
            if (!sts.scan_used) begin
               state_in = S_WLINK;
            end else if (sts.ptr_last) begin
               state_in = S_RESULT;
            end
         end
         S_WLINK: state_in = sts.prev_ok ? S_RESULT : S_TSCAN;
         S_TSCAN: begin
            if (sts.slot_free || sts.idx_last) state_in = S_RESULT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.code = ST_OK;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: cmd.load = req_valid;
         S_DISPATCH: begin
            unique case (sts.op)
               OP_DATA: cmd.wscan_init = 1'b1;
               OP_CREATE, OP_READ, OP_UPDATE, OP_DELETE: begin
                  cmd.end_write  = 1'b1;
                  cmd.find_clear = 1'b1;
               end
               default: ;
            endcase
         end
         S_FIND_RD: ;
         S_FIND_CMP: begin
            if (sts.id_match) begin
               if (sts.op == OP_CREATE) begin
                  cmd.set_code = 1'b1;
                  cmd.code     = ST_DUPLICATE;
               end
            end else if (sts.idx_last) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_NOT_FOUND;
            end else begin
               cmd.find_next = 1'b1;
            end
         end
         S_HEAD_RD: ;
         S_HEAD_LD: cmd.head_load = 1'b1;
         S_FREE_CHK: begin
            if (sts.ptr_ok) begin
               cmd.free_step = 1'b1;
            end else begin
               cmd.free_done = 1'b1;
               cmd.set_code  = 1'b1;
               cmd.code      = ST_OK;
            end
         end
         S_FREE_NX: cmd.ptr_follow = 1'b1;
         S_START: cmd.start_write = 1'b1;
         S_RESULT: cmd.emit_status = sts.out_ready;
         S_RD_CHK: begin
            if (!sts.ptr_ok) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_OK;
            end
         end
         S_RD_DATA: begin
            cmd.emit_char  = sts.out_ready;
            cmd.ptr_follow = sts.out_ready;
         end
         S_WSCAN: begin
            if (!sts.scan_used) begin
               cmd.take = 1'b1;
            end else if (sts.ptr_last) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_OK;
            end else begin
               cmd.wscan_next = 1'b1;
            end
         end
         S_WLINK: begin
            cmd.link       = 1'b1;
            cmd.set_code   = 1'b1;
            cmd.code       = ST_OK;
            cmd.find_clear = !sts.prev_ok;
         end
         S_TSCAN: begin
            if (sts.slot_free) begin
               cmd.tclaim = 1'b1;
            end else if (!sts.idx_last) begin
               cmd.find_next = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/lba_dp.sv =====
// ----------------------------------------------------------------------------
// Linked block allocator datapath
// Block and file table storage, free accounting, pointers and result register.
// ----------------------------------------------------------------------------
module lba_dp
   import lba_pkg::*;
#(
   parameter int BLOCK_COUNT = 16,
   parameter int ID_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [2:0]         req_op,
   input  logic [ID_BITS-1:0] req_file_id,
   input  logic [LEN_W-1:0]   req_length,
   input  logic [7:0]         req_data_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_char_out,
   output logic               rsp_last,
   output logic [FREE_W-1:0]  rsp_free_count
);

   localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int LW = $clog2(BLOCK_COUNT + 1);
   localparam int FW = $clog2(BLOCK_COUNT + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(BLOCK_COUNT);
   localparam logic [BW-1:0] LAST_IDX  = BW'(BLOCK_COUNT - 1);

   logic [ID_BITS-1:0] table_id_mem   [BLOCK_COUNT];
   logic [BW-1:0]      table_head_mem [BLOCK_COUNT];
   logic [7:0]         block_char_mem [BLOCK_COUNT];
   logic [LW-1:0]      next_link_mem  [BLOCK_COUNT];

   logic [BLOCK_COUNT-1:0] used_ff;
   logic [BLOCK_COUNT-1:0] valid_ff;
   logic [FW-1:0]         free_total_ff;
   logic [FW-1:0]         free_total_in;
   logic [LEN_W-1:0]      write_left_ff;
   logic [LW-1:0]         write_prev_ff;
   logic [BW-1:0]         write_scan_ff;
   logic [ID_BITS-1:0]    write_owner_ff;
   op_type                op_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [7:0]            char_ff;
   logic [BW-1:0]         idx_ff;
   logic [LW-1:0]         ptr_ff;
   logic [BW-1:0]         alloc_ff;
   status_type            code_ff;
   logic [ID_BITS-1:0]    id_rd_ff;
   logic [BW-1:0]         head_rd_ff;
   logic [7:0]            char_rd_ff;
   logic [LW-1:0]         link_rd_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [7:0]            rsp_char_ff;
   logic                  rsp_last_ff;
   logic [FREE_W-1:0]     rsp_free_ff;
   logic                  start_fail;
   logic                  link_ok;

   assign start_fail = (int'(len_ff) > MAX_LEN) || (int'(len_ff) > int'(free_total_ff));
   assign link_ok    = (link_rd_ff < NULL_LINK) && used_ff[link_rd_ff[BW-1:0]];

   always_comb begin
      sts.op         = op_ff;
      sts.write_idle = (write_left_ff == '0);
      sts.id_match   = valid_ff[idx_ff] && (id_rd_ff == id_ff);
      sts.idx_last   = (idx_ff == LAST_IDX);
      sts.ptr_ok     = (ptr_ff < NULL_LINK) && used_ff[ptr_ff[BW-1:0]];
      sts.link_ok    = link_ok;
      sts.scan_used  = used_ff[ptr_ff[BW-1:0]];
      sts.ptr_last   = (ptr_ff == LW'(BLOCK_COUNT - 1));
      sts.slot_free  = !valid_ff[idx_ff];
      sts.prev_ok    = (write_prev_ff < NULL_LINK);
      sts.out_ready  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      free_total_in = free_total_ff;
      if (cmd.end_write) begin
         free_total_in = free_total_ff + FW'(write_left_ff);
      end else if (cmd.free_step) begin
         free_total_in = free_total_ff + FW'(1);
      end else if (cmd.start_write && !start_fail && len_ff != '0) begin
         free_total_in = free_total_ff - FW'(len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= '0;
         valid_ff       <= '0;
         free_total_ff  <= FW'(BLOCK_COUNT);
         write_left_ff  <= '0;
         write_prev_ff  <= NULL_LINK;
         write_scan_ff  <= '0;
         write_owner_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         free_total_ff <= free_total_in;
         if (cmd.end_write) begin
            write_left_ff <= '0;
            write_prev_ff <= NULL_LINK;
         end
         if (cmd.free_step) used_ff[ptr_ff[BW-1:0]] <= 1'b0;
         if (cmd.free_done) valid_ff[idx_ff] <= 1'b0;
         if (cmd.start_write && !start_fail && len_ff != '0) begin
            write_left_ff  <= len_ff;
            write_prev_ff  <= NULL_LINK;
            write_scan_ff  <= '0;
            write_owner_ff <= id_ff;
         end
         if (cmd.take) used_ff[ptr_ff[BW-1:0]] <= 1'b1;
         if (cmd.link) begin
            write_prev_ff <= LW'(alloc_ff);
            write_scan_ff <= alloc_ff;
            write_left_ff <= write_left_ff - LEN_W'(1);
         end
         if (cmd.tclaim) valid_ff[idx_ff] <= 1'b1;
         if (cmd.emit_status || cmd.emit_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_op);
         id_ff   <= req_file_id;
         len_ff  <= req_length;
         char_ff <= req_data_char;
      end
      if (cmd.find_clear) begin
         idx_ff <= '0;
      end else if (cmd.find_next) begin
         idx_ff <= idx_ff + BW'(1);
      end
      if (cmd.wscan_init) begin
         ptr_ff <= LW'(write_scan_ff);
      end else if (cmd.wscan_next) begin
         ptr_ff <= ptr_ff + LW'(1);
      end else if (cmd.head_load) begin
         ptr_ff <= LW'(head_rd_ff);
      end else if (cmd.ptr_follow) begin
         ptr_ff <= link_rd_ff;
      end
      if (cmd.take) alloc_ff <= ptr_ff[BW-1:0];
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end else if (cmd.start_write) begin
         code_ff <= start_fail ? ST_NO_SPACE : ST_OK;
      end
      if (cmd.emit_status) begin
         rsp_status_ff <= code_ff;
         rsp_char_ff   <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_free_ff   <= FREE_W'(free_total_ff);
      end else if (cmd.emit_char) begin
         rsp_status_ff <= ST_OK;
         rsp_char_ff   <= char_rd_ff;
         rsp_last_ff   <= !link_ok;
         rsp_free_ff   <= FREE_W'(free_total_ff);
      end
   end

   always_ff @(posedge clock) begin
      id_rd_ff   <= table_id_mem[idx_ff];
      head_rd_ff <= table_head_mem[idx_ff];
      if (cmd.tclaim) begin
         table_id_mem[idx_ff]   <= write_owner_ff;
         table_head_mem[idx_ff] <= alloc_ff;
      end
   end

   always_ff @(posedge clock) begin
      char_rd_ff <= block_char_mem[ptr_ff[BW-1:0]];
      if (cmd.take) block_char_mem[ptr_ff[BW-1:0]] <= char_ff;
   end

   always_ff @(posedge clock) begin
      link_rd_ff <= next_link_mem[ptr_ff[BW-1:0]];
      if (cmd.take) begin
         next_link_mem[ptr_ff[BW-1:0]] <= NULL_LINK;
      end else if (cmd.link && write_prev_ff < NULL_LINK) begin
         next_link_mem[write_prev_ff[BW-1:0]] <= LW'(alloc_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_char_out   = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

// ===== rtl/linked_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Linked block allocator
// Stores files as linked chains of one-character blocks with a file table.
//
//   Channel   Ports                                         Direction
//   req       valid, stall, op, file_id, length, data_char  in
//   rsp       valid, stall, status, char_out, last, free_count  out
//
// One request is processed at a time; the request side stalls until it ends.
// A header searches the file table slot by slot, then walks a chain block by
// block for read, update and delete. A data character scans the block map
// one block per cycle from the last allocated block, plus a table slot scan
// for the first character of a file. Reset is synchronous and empties the
// store; the result register holds a stalled result and frees as soon as it
// is taken.
// ----------------------------------------------------------------------------
module linked_block_allocator
   import lba_pkg::*;
#(
   parameter int BLOCK_COUNT = 16,
   parameter int ID_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [ID_BITS-1:0] req_file_id,
   input  logic [4:0]         req_length,
   input  logic [7:0]         req_data_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_char_out,
   output logic               rsp_last,
   output logic [4:0]         rsp_free_count
);

   cmd_type cmd;
   sts_type sts;

   lba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lba_dp #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_file_id    (req_file_id),
      .req_length     (req_length),
      .req_data_char  (req_data_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_char_out   (rsp_char_out),
      .rsp_last       (rsp_last),
      .rsp_free_count (rsp_free_count)
   );

   a_emit_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_status || cmd.emit_char) |-> sts.out_ready)
      else $error("Result issued while the result register was occupied.");

   a_emit_single: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_status && cmd.emit_char))
      else $error("Two result kinds issued in one cycle.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Request side not stalled after a request was accepted.");

endmodule
